// File: src/cdq_pkg.sv
// Package for the circular deque: types, codes and size constants.
package cdq_pkg;

    localparam int CDQ_DEPTH   = 16;
    localparam int DATA_W      = 32;
    localparam int OP_W        = 3;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_QUERY      = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE  = 1'b0,
        S_FETCH = 1'b1
    } state_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } ram_ctl_t;

endpackage

// File: src/cdq_ram.sv
// Element store: one write port, one read port with registered read data.
module cdq_ram
    import cdq_pkg::*;
#(
    parameter int DEPTH = CDQ_DEPTH,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  ram_ctl_t          ctl,
    input  logic [AW-1:0]     wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [AW-1:0]     rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: src/circular_deque.sv
// Top level of the circular deque: ring pointers, cached ends and result register.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------------------
//  in      | input     | in_valid/in_stall  | operation, push_value
//  out     | output    | out_valid/out_stall| status, front_value, back_value,
//          |           |                    | element_count, empty, is_full
//
// Push, query, rejected ops and a pop of the last element finish in the accept
// cycle: the result word is in the output register at the next edge.
// A pop that leaves elements behind goes through the FETCH state: the new end element comes
// from one read of the element store (registered read data).
// With out_stall low, one word per cycle is sustained except for such pops.
// rst_n clears pointers, count, FSM and output valid; the store itself is not
// cleared, only written entries are ever read. A stalled result blocks input.
module circular_deque
    import cdq_pkg::*;
#(
    parameter int DEPTH = CDQ_DEPTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [OP_W-1:0]            operation,
    input  logic signed [DATA_W-1:0]   push_value,

    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [STATUS_W-1:0]        status,
    output logic signed [DATA_W-1:0]   front_value,
    output logic signed [DATA_W-1:0]   back_value,
    output logic [COUNT_OUT_W-1:0]     element_count,
    output logic                       empty,
    output logic                       is_full
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    // control state
    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              fetch_front_reg, fetch_front_next;
    logic              out_valid_reg, out_valid_next;

    // cached front/back elements (payload, no reset)
    logic [DATA_W-1:0] front_val_reg, front_val_next;
    logic [DATA_W-1:0] back_val_reg, back_val_next;

    // output word register
    logic [STATUS_W-1:0]    status_reg;
    logic [DATA_W-1:0]      front_out_reg, back_out_reg;
    logic [COUNT_OUT_W-1:0] count_out_reg;
    logic                   empty_out_reg, full_out_reg;

    // store interface
    ram_ctl_t          ram_ctl;
    logic [IDX_W-1:0]  wr_addr, rd_addr;
    logic [DATA_W-1:0] rd_data;

    logic    in_fire, out_fire;
    logic    go_fetch, load_out;
    status_t status_next;
    logic    cur_empty, cur_full, new_empty;
    logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
        ring_next = (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
        ring_prev = (i == '0) ? LAST_IDX : i - 1'b1;
    endfunction

    cdq_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .ctl     (ram_ctl),
        .wr_addr (wr_addr),
        .wr_data (push_value),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_fire   = in_valid && !in_stall;
    assign out_fire  = out_valid_reg && !out_stall;
    assign cur_empty = (count_reg == '0);
    assign cur_full  = (count_reg == FULL_CNT);

    // operation decode and pointer / cache update
    always_comb
    begin
        head_next        = head_reg;
        tail_next        = tail_reg;
        count_next       = count_reg;
        front_val_next   = front_val_reg;
        back_val_next    = back_val_reg;
        fetch_front_next = fetch_front_reg;
        status_next      = ST_DONE;
        ram_ctl          = '0;
        wr_addr          = '0;
        rd_addr          = '0;
        go_fetch         = 1'b0;
        load_out         = 1'b0;

        if (state_reg == S_FETCH)
        begin
            // read data of the new end element has arrived
            load_out = 1'b1;
            if (fetch_front_reg)
            begin
                front_val_next = rd_data;
            end
            else
            begin
                back_val_next = rd_data;
            end
        end
        else if (in_fire)
        begin
            case (op_t'(operation))
                OP_PUSH_FRONT:
                begin
                    if (cur_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        head_next      = cur_empty ? '0 : ring_prev(head_reg);
                        tail_next      = cur_empty ? '0 : tail_reg;
                        wr_addr        = head_next;
                        ram_ctl.wr_en  = 1'b1;
                        front_val_next = push_value;
                        back_val_next  = cur_empty ? push_value : back_val_reg;
                        count_next     = count_reg + 1'b1;
                    end
                end
                OP_PUSH_BACK:
                begin
                    if (cur_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        head_next      = cur_empty ? '0 : head_reg;
                        tail_next      = cur_empty ? '0 : ring_next(tail_reg);
                        wr_addr        = tail_next;
                        ram_ctl.wr_en  = 1'b1;
                        back_val_next  = push_value;
                        front_val_next = cur_empty ? push_value : front_val_reg;
                        count_next     = count_reg + 1'b1;
                    end
                end
                OP_POP_FRONT:
                begin
                    if (cur_empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else if (count_reg == CNT_W'(1))
                    begin
                        head_next  = '0;
                        tail_next  = '0;
                        count_next = '0;
                    end
                    else
                    begin
                        head_next        = ring_next(head_reg);
                        rd_addr          = head_next;
                        ram_ctl.rd_en    = 1'b1;
                        count_next       = count_reg - 1'b1;
                        fetch_front_next = 1'b1;
                        go_fetch         = 1'b1;
                    end
                end
                OP_POP_BACK:
                begin
                    if (cur_empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else if (count_reg == CNT_W'(1))
                    begin
                        head_next  = '0;
                        tail_next  = '0;
                        count_next = '0;
                    end
                    else
                    begin
                        tail_next        = ring_prev(tail_reg);
                        rd_addr          = tail_next;
                        ram_ctl.rd_en    = 1'b1;
                        count_next       = count_reg - 1'b1;
                        fetch_front_next = 1'b0;
                        go_fetch         = 1'b1;
                    end
                end
                default:
                begin
                    // query and unused codes: no change
                    status_next = ST_DONE;
                end
            endcase
            load_out = !go_fetch;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (go_fetch)
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // handshake outputs
    always_comb
    begin
        in_stall       = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign new_empty = (count_next == '0);
    assign count_ext = {{COUNT_OUT_W{1'b0}}, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            head_reg        <= '0;
            tail_reg        <= '0;
            count_reg       <= '0;
            fetch_front_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            count_reg       <= count_next;
            fetch_front_reg <= fetch_front_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_val_reg <= front_val_next;
        back_val_reg  <= back_val_next;
        if (load_out)
        begin
            status_reg    <= status_next;
            front_out_reg <= new_empty ? '1 : front_val_next;
            back_out_reg  <= new_empty ? '1 : back_val_next;
            count_out_reg <= count_ext[COUNT_OUT_W-1:0];
            empty_out_reg <= new_empty;
            full_out_reg  <= (count_next == FULL_CNT);
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign front_value   = front_out_reg;
    assign back_value    = back_out_reg;
    assign element_count = count_out_reg;
    assign empty         = empty_out_reg;
    assign is_full       = full_out_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("element count above capacity");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == '0 && tail_reg == '0))
        else $error("empty deque with pointers off entry 0");

    a_fetch_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH) |-> !out_valid_reg)
        else $error("store read pending while output word still held");

    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (out_valid_reg || state_reg == S_FETCH))
        else $error("accepted word produced no result path");

endmodule
